### sv/fasc_pkg.sv
// ----------------------------------------------------------------------------
// fasc_pkg: shared types and constants of the frame-aged slot cache
// Beat layouts, result status codes, controller states and register indexes.
// ----------------------------------------------------------------------------
package fasc_pkg;

  localparam int COLUMNS_DEF = 10;
  localparam int ROWS_DEF    = 10;

  localparam int KEY_W    = 36;
  localparam int STAMP_W  = 32;
  localparam int DRAWN_W  = 8;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [DRAWN_W-1:0] DRAW_BUDGET_RST = 8'd6;

  // Register indexes, taken from paddr bit 2.
  localparam logic REG_SHEET_READY = 1'b0;
  localparam logic REG_DRAW_BUDGET = 1'b1;

  localparam logic KIND_REQUEST     = 1'b0;
  localparam logic KIND_BEGIN_FRAME = 1'b1;

  typedef enum logic [2:0] {
    STAT_HIT         = 3'd0,
    STAT_FILLED      = 3'd1,
    STAT_BUDGET      = 3'd2,
    STAT_NO_SLOT     = 3'd3,
    STAT_NOT_READY   = 3'd4,
    STAT_FRAME_BEGUN = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] plant_id;
    logic [1:0]         stage;
    logic [1:0]         season;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] slot_index;
    logic [3:0] sheet_column;
    logic [3:0] sheet_row;
    logic       evicted;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] last_used;
  } slot_entry_t;

endpackage

### sv/frame_aged_slot_cache_core.sv
// ----------------------------------------------------------------------------
// frame_aged_slot_cache_core: sprite slot cache with frame-aged LRU refill
// Keys and last-use stamps live in one synchronous slot memory. A request
// scans the occupied slots for a hit while tracking the oldest evictable slot.
// ----------------------------------------------------------------------------
//
//  Port group   Direction  Beat contents
//  in_*         input      in_item_t: kind, plant_id, stage, season
//  out_*        output     out_item_t: status, slot_index, column, row, evicted
//  cfg_*        APB        sheet_ready at 0x0, draw_budget at 0x4
//
// A begin-frame beat goes from the idle state straight to the result state.
// A request's time is set by the one-slot-per-cycle scan of the occupied slots,
// at most COLUMNS*ROWS. Slots fill in order and are never freed, so a fill
// count marks the occupied ones and no clearing pass follows reset. One item
// is in work at a time; a result waiting under out_stall holds the next one
// in its result state.

module frame_aged_slot_cache_core
  import fasc_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,

  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,

  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int SLOTS = COLUMNS * ROWS;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(ROWS + 1);

  // Configuration registers
  logic               sheet_ready_r;
  logic [DRAWN_W-1:0] draw_budget_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sheet_ready_r <= 1'b0;
      draw_budget_r <= DRAW_BUDGET_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_SHEET_READY: sheet_ready_r <= cfg_pwdata[0];
        REG_DRAW_BUDGET: draw_budget_r <= cfg_pwdata[DRAWN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_SHEET_READY: cfg_prdata = {{(CFG_DW-1){1'b0}}, sheet_ready_r};
      REG_DRAW_BUDGET: cfg_prdata = {{(CFG_DW-DRAWN_W){1'b0}}, draw_budget_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // Slot memory
  slot_entry_t slot_mem [SLOTS];
  slot_entry_t rd_data_r;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  slot_entry_t mem_wd;
  logic        rd_en;
  logic [AW-1:0] rd_addr_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem[rd_addr_r];
    end
  end

  // Control and datapath state
  state_t state_r, state_nxt;

  logic [STAMP_W-1:0] frame_r;
  logic [DRAWN_W-1:0] drawn_r;
  logic [CNT_W-1:0]   fill_cnt_r;
  logic [CW-1:0]      fill_col_r;
  logic [RW-1:0]      fill_row_r;

  logic [KEY_W-1:0]   key_r;

  logic [CW-1:0]      rd_col_r;
  logic [RW-1:0]      rd_row_r;
  logic               issue_r;

  logic               dv_r;
  logic [AW-1:0]      d_addr_r;
  logic [CW-1:0]      d_col_r;
  logic [RW-1:0]      d_row_r;

  logic               cand_vld_r;
  logic [AW-1:0]      cand_addr_r;
  logic [CW-1:0]      cand_col_r;
  logic [RW-1:0]      cand_row_r;
  logic [STAMP_W-1:0] cand_stamp_r;

  status_t            res_status_r;
  logic [AW-1:0]      res_slot_r;
  logic [CW-1:0]      res_col_r;
  logic [RW-1:0]      res_row_r;
  logic               res_evict_r;

  logic               out_valid_r;
  out_item_t          out_data_r;

  logic in_acc;
  logic out_free;
  logic hit;
  logic last_data;
  logic last_issue;
  logic eligible;
  logic budget_spent;
  logic full;

  assign in_acc       = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign hit          = dv_r && (rd_data_r.key == key_r);
  assign last_data    = dv_r && (CNT_W'(d_addr_r) == fill_cnt_r - CNT_W'(1));
  assign last_issue   = CNT_W'(rd_addr_r) == fill_cnt_r - CNT_W'(1);
  // Slots stamped in this frame or the one before are not evictable.
  assign eligible     = ({1'b0, rd_data_r.last_used} + (STAMP_W+1)'(1))
                        < {1'b0, frame_r};
  assign budget_spent = drawn_r >= draw_budget_r;
  assign full         = fill_cnt_r == CNT_W'(SLOTS);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.kind == KIND_BEGIN_FRAME || !sheet_ready_r) begin
            state_nxt = ST_RESULT;
          end else if (fill_cnt_r == '0) begin
            state_nxt = ST_DECIDE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_RESULT;
        end else if (last_data) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory control
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = d_addr_r;
    mem_wd   = '{key: key_r, last_used: frame_r};
    unique case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_SCAN: begin
        rd_en  = issue_r;
        mem_we = hit;
      end
      ST_DECIDE: begin
        if (!budget_spent) begin
          if (!full) begin
            mem_we = 1'b1;
            mem_wa = fill_cnt_r[AW-1:0];
          end else if (cand_vld_r) begin
            mem_we = 1'b1;
            mem_wa = cand_addr_r;
          end
        end
      end
      ST_RESULT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frame_r     <= '0;
      drawn_r     <= '0;
      fill_cnt_r  <= '0;
      fill_col_r  <= '0;
      fill_row_r  <= '0;
      issue_r     <= 1'b0;
      dv_r        <= 1'b0;
      cand_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (out_valid_r && !out_stall && state_r != ST_RESULT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            key_r       <= {in_data.plant_id, in_data.stage, in_data.season};
            rd_addr_r   <= '0;
            rd_col_r    <= '0;
            rd_row_r    <= '0;
            dv_r        <= 1'b0;
            cand_vld_r  <= 1'b0;
            res_slot_r  <= '0;
            res_col_r   <= '0;
            res_row_r   <= '0;
            res_evict_r <= 1'b0;
            // Only a request with occupied slots to look at starts the reads.
            issue_r     <= (in_data.kind == KIND_REQUEST) && sheet_ready_r &&
                           (fill_cnt_r != '0);
            if (in_data.kind == KIND_BEGIN_FRAME) begin
              if (frame_r != '1) begin
                frame_r <= frame_r + STAMP_W'(1);
              end
              drawn_r      <= '0;
              res_status_r <= STAT_FRAME_BEGUN;
            end else if (!sheet_ready_r) begin
              res_status_r <= STAT_NOT_READY;
            end
          end
        end

        ST_SCAN: begin
          // Read issue stage
          dv_r <= issue_r && !hit;
          if (hit || (issue_r && last_issue)) begin
            issue_r <= 1'b0;
          end
          if (issue_r) begin
            d_addr_r <= rd_addr_r;
            d_col_r  <= rd_col_r;
            d_row_r  <= rd_row_r;
            if (!last_issue) begin
              rd_addr_r <= rd_addr_r + AW'(1);
              if (rd_col_r == CW'(COLUMNS - 1)) begin
                rd_col_r <= '0;
                rd_row_r <= rd_row_r + RW'(1);
              end else begin
                rd_col_r <= rd_col_r + CW'(1);
              end
            end
          end
          // Compare stage
          if (hit) begin
            res_status_r <= STAT_HIT;
            res_slot_r   <= d_addr_r;
            res_col_r    <= d_col_r;
            res_row_r    <= d_row_r;
          end else if (dv_r) begin
            if (eligible && (!cand_vld_r || rd_data_r.last_used < cand_stamp_r)) begin
              cand_vld_r   <= 1'b1;
              cand_addr_r  <= d_addr_r;
              cand_col_r   <= d_col_r;
              cand_row_r   <= d_row_r;
              cand_stamp_r <= rd_data_r.last_used;
            end
          end
        end

        ST_DECIDE: begin
          if (budget_spent) begin
            res_status_r <= STAT_BUDGET;
          end else if (!full || cand_vld_r) begin
            res_status_r <= STAT_FILLED;
            if (drawn_r != '1) begin
              drawn_r <= drawn_r + DRAWN_W'(1);
            end
            if (!full) begin
              res_slot_r <= fill_cnt_r[AW-1:0];
              res_col_r  <= fill_col_r;
              res_row_r  <= fill_row_r;
              fill_cnt_r <= fill_cnt_r + CNT_W'(1);
              if (fill_col_r == CW'(COLUMNS - 1)) begin
                fill_col_r <= '0;
                fill_row_r <= fill_row_r + RW'(1);
              end else begin
                fill_col_r <= fill_col_r + CW'(1);
              end
            end else begin
              res_slot_r  <= cand_addr_r;
              res_col_r   <= cand_col_r;
              res_row_r   <= cand_row_r;
              res_evict_r <= 1'b1;
            end
          end else begin
            res_status_r <= STAT_NO_SLOT;
          end
        end

        ST_RESULT: begin
          if (out_free) begin
            out_valid_r             <= 1'b1;
            out_data_r.status       <= res_status_r;
            out_data_r.slot_index   <= 7'(res_slot_r);
            out_data_r.sheet_column <= 4'(res_col_r);
            out_data_r.sheet_row    <= 4'(res_row_r);
            out_data_r.evicted      <= res_evict_r;
          end
        end

        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Assertions
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= CNT_W'(SLOTS))
    else $error("fill count exceeds slot count");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall)
    else $error("input taken while an item is in work");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_SCAN || state_r == ST_DECIDE))
    else $error("slot memory written outside scan or decide");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result raised without a finished item");

endmodule

### verif/fasc_checker.sv
// ----------------------------------------------------------------------------
// fasc_checker: result predictor and scoreboard for the slot cache
// Watches the request, result and register channels, keeps its own copy of
// the cache state, predicts each reply and compares it field by field.
// ----------------------------------------------------------------------------
module fasc_checker
  import fasc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,

  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,

  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic [CFG_DW-1:0] cfg_prdata,
  input  logic              cfg_pready,

  output int                mismatch_count,
  output int                replies_due
);

  localparam int SLOTS = COLUMNS_DEF * ROWS_DEF;

  logic               ready_reg;
  logic [DRAWN_W-1:0] budget_reg;
  logic [STAMP_W-1:0] frame_cnt;
  logic [DRAWN_W-1:0] drawn_cnt;
  logic               slot_used [SLOTS];
  logic [KEY_W-1:0]   slot_tag  [SLOTS];
  logic [STAMP_W-1:0] slot_stamp[SLOTS];

  out_item_t          expected_replies[$];
  out_item_t          want;
  out_item_t          reply;
  logic [CFG_DW-1:0]  reg_value;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $time, what);
    mismatch_count++;
  endtask

  task automatic set_slot_fields(inout out_item_t res, input int s);
    res.slot_index   = 7'(s);
    res.sheet_column = 4'(s % COLUMNS_DEF);
    res.sheet_row    = 4'(s / COLUMNS_DEF);
  endtask

  // Applies one beat to the cache copy and returns the reply it must produce.
  task automatic lookup_slot(input in_item_t it, output out_item_t res);
    logic [KEY_W-1:0] key;
    logic [32:0]      oldest;
    int               hit;
    int               chosen;
    bit               found_free;
    res        = '0;
    hit        = -1;
    chosen     = -1;
    found_free = 1'b0;
    key        = {it.plant_id, it.stage, it.season};
    if (it.kind == KIND_BEGIN_FRAME) begin
      if (frame_cnt != '1) frame_cnt = frame_cnt + 1'b1;
      drawn_cnt  = '0;
      res.status = STAT_FRAME_BEGUN;
    end else if (!ready_reg) begin
      res.status = STAT_NOT_READY;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && slot_used[i] && slot_tag[i] == key) hit = i;
      end
      if (hit >= 0) begin
        slot_stamp[hit] = frame_cnt;
        res.status = STAT_HIT;
        set_slot_fields(res, hit);
      end else if (drawn_cnt >= budget_reg) begin
        res.status = STAT_BUDGET;
      end else begin
        oldest = {1'b0, frame_cnt};
        for (int i = 0; i < SLOTS; i++) begin
          if (!found_free) begin
            if (!slot_used[i]) begin
              chosen     = i;
              found_free = 1'b1;
            end else if ({1'b0, slot_stamp[i]} + 33'd1 >= {1'b0, frame_cnt}) begin
              // Stamped this frame or the one before: not a victim.
            end else if (chosen < 0 || {1'b0, slot_stamp[i]} < oldest) begin
              chosen = i;
              oldest = {1'b0, slot_stamp[i]};
            end
          end
        end
        if (chosen < 0) begin
          res.status = STAT_NO_SLOT;
        end else begin
          res.status        = STAT_FILLED;
          res.evicted       = slot_used[chosen];
          set_slot_fields(res, chosen);
          slot_tag[chosen]   = key;
          slot_stamp[chosen] = frame_cnt;
          slot_used[chosen]  = 1'b1;
          if (drawn_cnt != '1) drawn_cnt = drawn_cnt + 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ready_reg      = 1'b0;
      budget_reg     = DRAW_BUDGET_RST;
      frame_cnt      = '0;
      drawn_cnt      = '0;
      mismatch_count = 0;
      expected_replies.delete();
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i]  = 1'b0;
        slot_tag[i]   = '0;
        slot_stamp[i] = '0;
      end
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr[2] == REG_SHEET_READY) ready_reg = cfg_pwdata[0];
          else budget_reg = cfg_pwdata[DRAWN_W-1:0];
        end else begin
          if (cfg_paddr[2] == REG_SHEET_READY) reg_value = {31'd0, ready_reg};
          else reg_value = {24'd0, budget_reg};
          if (cfg_prdata !== reg_value)
            report_mismatch($sformatf("register read at %0h: got %0h expected %0h",
                                      cfg_paddr, cfg_prdata, reg_value));
        end
      end

      // Results are retired before new requests so a same-edge beat pair
      // never matches a reply against its own request.
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          want = expected_replies.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status: got %0d expected %0d",
                                      out_data.status, want.status));
          if (out_data.slot_index !== want.slot_index)
            report_mismatch($sformatf("slot_index: got %0d expected %0d",
                                      out_data.slot_index, want.slot_index));
          if (out_data.sheet_column !== want.sheet_column)
            report_mismatch($sformatf("sheet_column: got %0d expected %0d",
                                      out_data.sheet_column, want.sheet_column));
          if (out_data.sheet_row !== want.sheet_row)
            report_mismatch($sformatf("sheet_row: got %0d expected %0d",
                                      out_data.sheet_row, want.sheet_row));
          if (out_data.evicted !== want.evicted)
            report_mismatch($sformatf("evicted: got %0d expected %0d",
                                      out_data.evicted, want.evicted));
        end
      end

      if (in_valid && !in_stall) begin
        lookup_slot(in_data, reply);
        expected_replies.push_back(reply);
      end
    end
    replies_due <= expected_replies.size();
  end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: top-level testbench of the frame-aged slot cache
// Drives directed and random request and frame beats through several register
// settings, stalls both channels at random and reports the final verdict.
// ----------------------------------------------------------------------------
module tb;
  import fasc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int KEY_POOL_MAX   = 160;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  in_item_t          in_data     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  out_item_t         out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  logic              idle_on     = 1'b1;
  int                stall_left  = 0;
  int                quiet_cycles = 0;
  int                mismatch_count;
  int                replies_due;
  in_item_t          known_keys[$];

  frame_aged_slot_cache_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  fasc_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (mismatch_count),
    .replies_due    (replies_due)
  );

  always #5 clk = ~clk;

  // Result-side back-pressure in random bursts.
  always @(posedge clk) begin
    if (!idle_on) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // The run is declared hung once nothing moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t mk_req(input logic [31:0] id, input logic [1:0] st,
                                      input logic [1:0] se);
    in_item_t it;
    it.kind     = KIND_REQUEST;
    it.plant_id = id;
    it.stage    = st;
    it.season   = se;
    return it;
  endfunction

  function automatic in_item_t frame_item();
    in_item_t it;
    it.kind     = KIND_BEGIN_FRAME;
    it.plant_id = $urandom;
    it.stage    = 2'($urandom_range(0, 3));
    it.season   = 2'($urandom_range(0, 3));
    return it;
  endfunction

  // Requests revisit earlier keys often enough to hit; fresh keys keep the
  // pool larger than the cache so that misses and evictions follow.
  function automatic in_item_t sprite_request(input int reuse_pct);
    in_item_t    it;
    logic [31:0] id;
    if (known_keys.size() > 0 && $urandom_range(0, 99) < reuse_pct) begin
      it = known_keys[$urandom_range(0, known_keys.size() - 1)];
    end else begin
      case ($urandom_range(0, 7))
        0:       id = 32'h8000_0000;
        1:       id = 32'h7FFF_FFFF;
        2:       id = 32'hFFFF_FFFF;
        3, 4:    id = $urandom_range(0, 15);
        default: id = $urandom;
      endcase
      it = mk_req(id, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      known_keys.push_back(it);
      if (known_keys.size() > KEY_POOL_MAX) void'(known_keys.pop_front());
    end
    return it;
  endfunction

  task automatic send_beat(input in_item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only with the cache drained of outstanding work.
  task automatic reconfigure(input logic ready, input logic [7:0] budget);
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    apb_access(1'b1, REG_SHEET_READY, {31'd0, ready});
    apb_access(1'b1, REG_DRAW_BUDGET, {24'd0, budget});
    apb_access(1'b0, REG_SHEET_READY, '0);
    apb_access(1'b0, REG_DRAW_BUDGET, '0);
  endtask

  task automatic run_frames(input int beats, input int max_frame, input int reuse_pct);
    int left;
    left = 0;
    for (int n = 0; n < beats; n++) begin
      if (left == 0) begin
        send_beat(frame_item());
        left = $urandom_range(1, max_frame);
        // Now and then several frames begin back to back.
        if ($urandom_range(0, 19) == 0) left = 0;
      end else begin
        send_beat(sprite_request(reuse_pct));
        left--;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: sheet not ready, so only frames act.
    send_beat(mk_req(32'd5, 2'd1, 2'd2));
    send_beat(frame_item());

    reconfigure(1'b1, 8'd255);
    send_beat(mk_req(32'h8000_0000, 2'd3, 2'd3));
    send_beat(mk_req(32'h7FFF_FFFF, 2'd0, 2'd0));
    send_beat(mk_req(32'hFFFF_FFFF, 2'd3, 2'd0));
    send_beat(mk_req(32'h0000_0000, 2'd0, 2'd3));
    send_beat(mk_req(32'h8000_0000, 2'd3, 2'd3));
    send_beat(mk_req(32'h8000_0000, 2'd2, 2'd3));
    send_beat(frame_item());
    send_beat(mk_req(32'h7FFF_FFFF, 2'd0, 2'd0));

    // A stored key is still refused while the sheet is missing.
    reconfigure(1'b0, 8'd255);
    send_beat(mk_req(32'hFFFF_FFFF, 2'd3, 2'd0));
    send_beat(frame_item());

    // With no budget, hits still pass and misses are refused.
    reconfigure(1'b1, 8'd0);
    send_beat(mk_req(32'h0000_0000, 2'd0, 2'd3));
    send_beat(mk_req(32'h1234_5678, 2'd1, 2'd1));

    reconfigure(1'b1, 8'd2);
    send_beat(frame_item());
    send_beat(mk_req(32'h0BAD_F00D, 2'd1, 2'd2));
    send_beat(mk_req(32'hF00D_0BAD, 2'd2, 2'd1));
    send_beat(mk_req(32'h5555_AAAA, 2'd3, 2'd1));
    send_beat(mk_req(32'h0BAD_F00D, 2'd1, 2'd2));

    // Long frames fill the whole sheet and then run out of victims.
    reconfigure(1'b1, 8'd255);
    run_frames(300, 130, 30);

    reconfigure(1'b1, 8'd3);
    run_frames(400, 10, 50);

    reconfigure(1'b0, 8'd6);
    run_frames(60, 8, 50);

    idle_on <= 1'b0;
    reconfigure(1'b1, 8'd0);
    run_frames(100, 8, 70);

    idle_on <= 1'b1;
    reconfigure(1'b1, 8'($urandom_range(1, 254)));
    run_frames(400, 20, 45);

    idle_on <= 1'b0;
    reconfigure(1'b1, 8'd255);
    run_frames(440, 20, 45);

    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/fasc_pkg.sv
sv/frame_aged_slot_cache_core.sv
verif/fasc_checker.sv
verif/tb.sv
